>>> src/sofx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sofx_pkg;

   localparam int unsigned BUF_BYTES_DEF = 2048;
   localparam int unsigned HDR_MIN       = 6;
   localparam int unsigned HDR_EXTRA     = 8;
   localparam int unsigned LEN_LO_POS    = 4;
   localparam int unsigned LEN_HI_POS    = 5;

   localparam int unsigned TOTAL_W = 17;
   localparam int unsigned LEN_OUT_W = 12;

   localparam logic CSR_SOF_BYTE  = 1'b0;
   localparam logic CSR_MAX_FRAME = 1'b1;

   typedef enum logic [1:0] {
      REQ_BYTE  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_NOP   = 2'd3
   } sofx_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_CHK,
      ST_LO,
      ST_HI,
      ST_EVAL,
      ST_RDATA,
      ST_DONE
   } sofx_state_type;

endpackage

`default_nettype wire

>>> src/sof_length_frame_extractor.sv
// A received byte with no frame search goes through the done state to its response word;
// a read goes through the read-data state first, and when it ends a frame the search
// resumes before the response. The search uses the head and check states per dropped byte
// and also the length and evaluate states per header check, all through the single read
// port of the byte store. One word is in work at a time; ready is low meanwhile.
// Reset (synchronous, active high) empties the store, clears any pending frame, keeps its bytes.
`timescale 1ns / 1ps
`default_nettype none

module sof_length_frame_extractor #(
   parameter int unsigned BUF_BYTES = sofx_pkg::BUF_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_rx_byte,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_frame_ready,
   output      logic [11:0] rsp_frame_length,
   output      logic        rsp_out_valid,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_out_last,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   import sofx_pkg::*;

   localparam int unsigned AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
   localparam int unsigned FW = $clog2(BUF_BYTES + 1);
   localparam int unsigned LW = (FW > LEN_OUT_W) ? FW : LEN_OUT_W;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [FW-1:0] off);
      logic [FW:0] s;
      s = (FW+1)'(base) + (FW+1)'(off);
      if (s >= (FW+1)'(BUF_BYTES)) begin
         s = s - (FW+1)'(BUF_BYTES);
      end
      return s[AW-1:0];
   endfunction

   logic [7:0] store_mem [BUF_BYTES];

   sofx_state_type state_ff, state_in;

   logic [AW-1:0]      head_ff, head_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic               pend_ff, pend_in;
   logic [FW-1:0]      plen_ff, plen_in;
   logic [FW-1:0]      roff_ff, roff_in;
   logic [7:0]         lo_ff, lo_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               ov_ff, ov_in;
   logic [7:0]         ob_ff, ob_in;
   logic               ol_ff, ol_in;
   logic [7:0]         sof_ff;
   logic [15:0]        max_ff;
   logic [7:0]         rd_data_ff;
   logic [AW-1:0]      rd_addr_in;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;

   logic               rsp_valid_ff;
   logic               rsp_ready_ff;
   logic [11:0]        rsp_len_ff;
   logic               rsp_ov_ff;
   logic [7:0]         rsp_ob_ff;
   logic               rsp_ol_ff;

   logic               accept;
   logic               full;
   logic               rd_ok;
   logic               rd_end;
   logic [FW:0]        roff_inc;
   logic [LW-1:0]      len_ext;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign full      = (fill_ff >= FW'(BUF_BYTES));
   assign rd_ok     = pend_ff && (roff_ff < plen_ff);
   assign roff_inc  = (FW+1)'(roff_ff) + (FW+1)'(1);
   assign rd_end    = (roff_inc >= (FW+1)'(plen_ff));
   assign len_ext   = LW'(plen_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_BYTE:  state_in = (pend_ff && !full) ? ST_DONE : ST_HEAD;
                  REQ_READ:  state_in = rd_ok ? ST_RDATA : ST_DONE;
                  REQ_FLUSH: state_in = ST_DONE;
                  REQ_NOP:   state_in = ST_DONE;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_HEAD:  state_in = (fill_ff == '0) ? ST_DONE : ST_CHK;
         ST_CHK: begin
            priority if (rd_data_ff != sof_ff)    state_in = ST_HEAD;
            else if (fill_ff < FW'(HDR_MIN))      state_in = ST_DONE;
            else                                  state_in = ST_LO;
         end
         ST_LO:    state_in = ST_HI;
         ST_HI:    state_in = ST_EVAL;
         ST_EVAL: begin
            priority if (total_ff > TOTAL_W'(BUF_BYTES)) state_in = ST_HEAD;
            else                                          state_in = ST_DONE;
         end
         ST_RDATA: state_in = rd_end ? ST_HEAD : ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      head_in    = head_ff;
      fill_in    = fill_ff;
      pend_in    = pend_ff;
      plen_in    = plen_ff;
      roff_in    = roff_ff;
      lo_in      = lo_ff;
      total_in   = total_ff;
      ov_in      = ov_ff;
      ob_in      = ob_ff;
      ol_in      = ol_ff;
      mem_we     = 1'b0;
      mem_waddr  = wrap_add(head_ff, fill_ff);
      rd_addr_in = head_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr_in = wrap_add(head_ff, roff_ff);
            if (accept) begin
               ov_in = 1'b0;
               ob_in = '0;
               ol_in = 1'b0;
               unique case (req_type)
                  REQ_BYTE: begin
                     mem_we = 1'b1;
                     if (full) begin
                        mem_waddr = '0;
                        head_in   = '0;
                        fill_in   = FW'(1);
                        pend_in   = 1'b0;
                        plen_in   = '0;
                        roff_in   = '0;
                     end else begin
                        fill_in = fill_ff + FW'(1);
                     end
                  end
                  REQ_FLUSH: begin
                     head_in = '0;
                     fill_in = '0;
                     pend_in = 1'b0;
                     plen_in = '0;
                     roff_in = '0;
                  end
                  REQ_READ: begin
                  end
                  REQ_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HEAD: begin
            rd_addr_in = head_ff;
         end
         ST_CHK: begin
            rd_addr_in = wrap_add(head_ff, FW'(LEN_LO_POS));
            if (rd_data_ff != sof_ff) begin
               if (fill_ff <= FW'(1)) begin
                  head_in = '0;
                  fill_in = '0;
               end else begin
                  head_in = wrap_add(head_ff, FW'(1));
                  fill_in = fill_ff - FW'(1);
               end
            end
         end
         ST_LO: begin
            rd_addr_in = wrap_add(head_ff, FW'(LEN_HI_POS));
            lo_in      = rd_data_ff;
         end
         ST_HI: begin
            total_in = TOTAL_W'({rd_data_ff, lo_ff}) + TOTAL_W'(HDR_EXTRA);
         end
         ST_EVAL: begin
            priority if (total_ff > TOTAL_W'(BUF_BYTES)) begin
               if (fill_ff <= FW'(1)) begin
                  head_in = '0;
                  fill_in = '0;
               end else begin
                  head_in = wrap_add(head_ff, FW'(1));
                  fill_in = fill_ff - FW'(1);
               end
            end else if (TOTAL_W'(fill_ff) < total_ff) begin
            end else if ({1'b0, max_ff} < total_ff) begin
               head_in = '0;
               fill_in = '0;
               pend_in = 1'b0;
               plen_in = '0;
               roff_in = '0;
            end else begin
               pend_in = 1'b1;
               plen_in = FW'(total_ff);
               roff_in = '0;
            end
         end
         ST_RDATA: begin
            ov_in = 1'b1;
            ob_in = rd_data_ff;
            if (rd_end) begin
               ol_in = 1'b1;
               if (plen_ff >= fill_ff) begin
                  head_in = '0;
                  fill_in = '0;
               end else begin
                  head_in = wrap_add(head_ff, plen_ff);
                  fill_in = fill_ff - plen_ff;
               end
               pend_in = 1'b0;
               plen_in = '0;
               roff_in = '0;
            end else begin
               roff_in = roff_inc[FW-1:0];
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= req_rx_byte;
      end
      rd_data_ff <= store_mem[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      total_ff <= total_in;
      ob_ff    <= ob_in;
      if (state_ff == ST_DONE) begin
         rsp_len_ff <= pend_ff ? len_ext[11:0] : 12'd0;
         rsp_ov_ff  <= ov_ff;
         rsp_ob_ff  <= ob_ff;
         rsp_ol_ff  <= ol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         plen_ff      <= '0;
         roff_ff      <= '0;
         ov_ff        <= 1'b0;
         ol_ff        <= 1'b0;
         sof_ff       <= 8'd0;
         max_ff       <= 16'hFFFF;
         rsp_valid_ff <= 1'b0;
         rsp_ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
         plen_ff  <= plen_in;
         roff_ff  <= roff_in;
         ov_ff    <= ov_in;
         ol_ff    <= ol_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SOF_BYTE:  sof_ff <= csr_wdata[7:0];
               CSR_MAX_FRAME: max_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (state_ff == ST_DONE) begin
            rsp_valid_ff <= 1'b1;
            rsp_ready_ff <= pend_ff;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_ready  = rsp_ready_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_out_valid    = rsp_ov_ff;
   assign rsp_out_byte     = rsp_ob_ff;
   assign rsp_out_last     = rsp_ol_ff;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import sofx_pkg::*;

   localparam int unsigned STORE_BYTES   = BUF_BYTES_DEF;
   localparam int unsigned RANDOM_PHASES = 7;
   localparam int unsigned PHASE_WORDS   = 280;
   localparam int unsigned DRAIN_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 20;

   typedef struct packed {
      logic        frame_ready;
      logic [11:0] frame_length;
      logic        out_valid;
      logic [7:0]  out_byte;
      logic        out_last;
   } status_word_type;

   typedef struct packed {
      sofx_req_type kind;
      logic [7:0]   data;
   } link_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_frame_ready;
   logic [11:0] rsp_frame_length;
   logic        rsp_out_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_SOF_BYTE;
   logic [15:0] csr_wdata = 16'h0000;

   link_item_type   link_items_q[$];
   status_word_type due_status_q[$];
   link_item_type   next_item;
   status_word_type want_word;

   int unsigned req_total = 0;
   int unsigned req_taken = 0;
   int unsigned live_items = 0;
   int unsigned err_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   logic [7:0]  held_bytes [0:STORE_BYTES-1];
   logic [10:0] held_head = '0;
   logic [11:0] held_fill = '0;
   logic        frame_held = 1'b0;
   logic [11:0] frame_len = '0;
   logic [11:0] read_pos = '0;
   logic [7:0]  sof_reg = 8'h00;
   logic [15:0] cap_reg = 16'hFFFF;

   sof_length_frame_extractor dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_ready  (rsp_frame_ready),
      .rsp_frame_length (rsp_frame_length),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] peek_held(input logic [11:0] off);
      logic [10:0] slot;
      slot = held_head + off[10:0];
      return held_bytes[slot];
   endfunction

   function automatic void drop_held(input logic [11:0] n);
      if (n >= held_fill) begin
         held_fill = '0;
         held_head = '0;
      end else begin
         held_head = held_head + n[10:0];
         held_fill = held_fill - n;
      end
   endfunction

   function automatic void wipe_held();
      held_fill  = '0;
      held_head  = '0;
      frame_held = 1'b0;
      frame_len  = '0;
      read_pos   = '0;
   endfunction

   function automatic void hunt_frame();
      logic [TOTAL_W-1:0] total;
      while (!frame_held) begin
         while (held_fill > 0 && peek_held(12'd0) != sof_reg)
            drop_held(12'd1);
         if (held_fill < HDR_MIN)
            return;
         total = TOTAL_W'({peek_held(12'(LEN_HI_POS)), peek_held(12'(LEN_LO_POS))})
               + TOTAL_W'(HDR_EXTRA);
         if (total > STORE_BYTES) begin
            drop_held(12'd1);
            continue;
         end
         if (held_fill < total)
            return;
         if (cap_reg < total) begin
            wipe_held();
            return;
         end
         frame_held = 1'b1;
         frame_len  = total[11:0];
         read_pos   = '0;
      end
   endfunction

   function automatic status_word_type deframe_step(input sofx_req_type kind,
                                                    input logic [7:0] data);
      status_word_type w;
      logic [10:0]     slot;
      w = '0;
      case (kind)
         REQ_BYTE: begin
            if (held_fill >= STORE_BYTES)
               wipe_held();
            slot = held_head + held_fill[10:0];
            held_bytes[slot] = data;
            held_fill = held_fill + 12'd1;
            hunt_frame();
         end
         REQ_READ: begin
            if (frame_held && read_pos < frame_len) begin
               w.out_valid = 1'b1;
               w.out_byte  = peek_held(read_pos);
               read_pos    = read_pos + 12'd1;
               if (read_pos >= frame_len) begin
                  w.out_last = 1'b1;
                  drop_held(frame_len);
                  frame_held = 1'b0;
                  frame_len  = '0;
                  read_pos   = '0;
                  hunt_frame();
               end
            end
         end
         REQ_FLUSH: wipe_held();
         default: ;
      endcase
      w.frame_ready  = frame_held;
      w.frame_length = frame_held ? frame_len : 12'd0;
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      err_count++;
      if (err_count <= 100)
         $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // drive: hold the word until taken, then pull the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            due_status_q.push_back(deframe_step(sofx_req_type'(req_type), req_rx_byte));
            req_taken++;
         end
         if (!req_valid || req_ready) begin
            if (link_items_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_item = link_items_q.pop_front();
               req_valid   <= 1'b1;
               req_type    <= next_item.kind;
               req_rx_byte <= next_item.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_status_q.size() == 0) begin
               report_mismatch("response word with nothing outstanding");
            end else begin
               want_word = due_status_q.pop_front();
               if (rsp_frame_ready !== want_word.frame_ready)
                  report_mismatch($sformatf("frame_ready got %0b want %0b",
                                            rsp_frame_ready, want_word.frame_ready));
               if (rsp_frame_length !== want_word.frame_length)
                  report_mismatch($sformatf("frame_length got %0d want %0d",
                                            rsp_frame_length, want_word.frame_length));
               if (rsp_out_valid !== want_word.out_valid)
                  report_mismatch($sformatf("out_valid got %0b want %0b",
                                            rsp_out_valid, want_word.out_valid));
               if (rsp_out_byte !== want_word.out_byte)
                  report_mismatch($sformatf("out_byte got %02h want %02h",
                                            rsp_out_byte, want_word.out_byte));
               if (rsp_out_last !== want_word.out_last)
                  report_mismatch($sformatf("out_last got %0b want %0b",
                                            rsp_out_last, want_word.out_last));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic push_item(input sofx_req_type kind, input logic [7:0] data);
      link_item_type it;
      it.kind = kind;
      it.data = data;
      link_items_q.push_back(it);
      req_total++;
      if (kind != REQ_NOP)
         live_items++;
   endtask

   task automatic push_bytes(input int unsigned n, input logic [7:0] sof,
                             input int unsigned sof_pct);
      repeat (n) begin
         if ($urandom_range(0, 99) < sof_pct)
            push_item(REQ_BYTE, sof);
         else
            push_item(REQ_BYTE, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic push_reads(input int unsigned n);
      repeat (n) push_item(REQ_READ, 8'($urandom_range(0, 255)));
   endtask

   task automatic push_header(input logic [7:0] sof, input logic [15:0] body_len);
      push_item(REQ_BYTE, sof);
      push_bytes(3, sof, 0);
      push_item(REQ_BYTE, body_len[7:0]);
      push_item(REQ_BYTE, body_len[15:8]);
   endtask

   function automatic int unsigned pick_body_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 88)
         return $urandom_range(0, 24);
      else if (r < 98)
         return $urandom_range(25, 150);
      return $urandom_range(151, 600);
   endfunction

   task automatic push_traffic(input logic [7:0] sof, input int unsigned budget);
      int unsigned start;
      int unsigned pick;
      int unsigned body;
      int unsigned r;
      start = live_items;
      while (live_items - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            body = pick_body_len();
            push_header(sof, 16'(body));
            push_bytes(body + 2, sof, 0);
            r = $urandom_range(0, 99);
            if (r < 60)
               push_reads(body + HDR_EXTRA);
            else if (r < 70)
               push_reads(body + HDR_EXTRA - 1);
            else if (r < 80)
               push_reads(body + HDR_EXTRA + 2);
         end else if (pick < 60) begin
            push_reads($urandom_range(1, 12));
         end else if (pick < 72) begin
            push_bytes($urandom_range(1, 6), sof, 25);
         end else if (pick < 80) begin
            if ($urandom_range(0, 1) == 0)
               push_header(sof, 16'h07F9);
            else
               push_header(sof, {8'($urandom_range(8, 255)), 8'($urandom_range(0, 255))});
            push_bytes($urandom_range(0, 3), sof, 25);
         end else if (pick < 86) begin
            body = $urandom_range(0, 24);
            push_header(sof, 16'(body));
            push_bytes($urandom_range(0, body + 1), sof, 0);
            if ($urandom_range(0, 1) == 0)
               push_item(REQ_FLUSH, 8'($urandom_range(0, 255)));
         end else if (pick < 90) begin
            push_item(REQ_FLUSH, 8'($urandom_range(0, 255)));
         end else if (pick < 94) begin
            push_item(REQ_NOP, 8'($urandom_range(0, 255)));
         end else begin
            push_item(sofx_req_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_drained();
      int unsigned n;
      n = 0;
      while ((req_taken != req_total || due_status_q.size() != 0) && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (n >= DRAIN_LIMIT)
         report_mismatch($sformatf("%0d words never taken, %0d responses missing",
                                   req_total - req_taken, due_status_q.size()));
   endtask

   task automatic csr_write(input logic idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SOF_BYTE)
         sof_reg = value[7:0];
      else
         cap_reg = value;
   endtask

   task automatic set_idling(input int unsigned mode);
      case (mode)
         0: begin
            send_idle_pct = 36;
            recv_idle_pct = 61;
         end
         1: begin
            send_idle_pct = 61;
            recv_idle_pct = 36;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic configure(input logic [7:0] sof, input logic [15:0] cap);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(CSR_SOF_BYTE, {8'($urandom_range(0, 255)), sof});
      csr_write(CSR_MAX_FRAME, cap);
   endtask

   initial begin
      logic [7:0]  phase_sof;
      logic [15:0] phase_cap;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_idling(0);
      configure(8'h00, 16'hFFFF);
      push_item(REQ_NOP, 8'hFF);
      push_item(REQ_READ, 8'h00);
      push_item(REQ_BYTE, 8'hFF);
      push_item(REQ_BYTE, 8'h00);
      push_item(REQ_BYTE, 8'hFF);
      push_item(REQ_BYTE, 8'h00);
      push_item(REQ_BYTE, 8'hFF);
      push_item(REQ_BYTE, 8'h00);
      push_item(REQ_BYTE, 8'h00);
      push_item(REQ_BYTE, 8'hFF);
      push_item(REQ_BYTE, 8'h00);
      push_item(REQ_BYTE, 8'h00);
      push_reads(8);
      push_item(REQ_BYTE, 8'h11);
      push_item(REQ_BYTE, 8'h22);
      push_item(REQ_BYTE, 8'h33);
      push_item(REQ_BYTE, 8'hFF);
      push_item(REQ_BYTE, 8'hFF);
      push_item(REQ_BYTE, 8'h00);
      push_item(REQ_FLUSH, 8'hFF);

      for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin phase_sof = 8'h7E; phase_cap = 16'd40;   end
            1: begin phase_sof = 8'hFF; phase_cap = 16'd0;    end
            2: begin phase_sof = 8'h00; phase_cap = 16'd2048; end
            3: begin phase_sof = 8'hA5; phase_cap = 16'd30;   end
            4: begin phase_sof = 8'h5A; phase_cap = 16'hFFFF; end
            5: begin phase_sof = 8'h3C; phase_cap = 16'd16;   end
            default: begin
               phase_sof = 8'($urandom_range(0, 255));
               phase_cap = 16'($urandom_range(8, 80));
            end
         endcase
         configure(phase_sof, phase_cap);
         set_idling(ph == 0 ? 0 : (ph < 4 ? 1 : 2));
         push_traffic(phase_sof, PHASE_WORDS);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (err_count == 0)
         $display("PASS sof_length_frame_extractor");
      else
         $display("FAIL sof_length_frame_extractor");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL sof_length_frame_extractor");
      $finish;
   end

endmodule
